// File: sv/dmv_pkg.sv
// Shared types, keyword table and lookup functions for the delivery method validator.
// No dependencies; every other source file but dmv_out_if imports this package.
package dmv_pkg;

	// Longest keyword accepted before a word is ruled too long.
	localparam int MAX_WORD_LEN = 9;
	localparam int POS_W        = $clog2(MAX_WORD_LEN + 1);
	localparam int NUM_WORDS    = 10;
	localparam int KW_CHARS     = 9;
	localparam int KW_IDX_W     = $clog2(NUM_WORDS);
	localparam int CH_IDX_W     = $clog2(KW_CHARS);

	typedef logic [7:0]           char_t;
	typedef logic [NUM_WORDS-1:0] word_mask_t;
	typedef logic [POS_W-1:0]     pos_t;

	localparam word_mask_t ALL_WORDS = '1;
	localparam char_t CH_SPACE  = 8'h20;
	localparam char_t CH_DOLLAR = 8'h24;

	// Keyword text, right-justified: the first letter sits at index length-1.
	localparam logic [KW_CHARS-1:0][7:0] KW_TEXT [NUM_WORDS] = '{
		"any", "mhs", "ia5", "telex", "g3fax",
		"g4fax", "teletex", "physical", "videotex", "telephone"
	};
	localparam pos_t KW_LEN [NUM_WORDS] = '{
		POS_W'(3), POS_W'(3), POS_W'(3), POS_W'(5), POS_W'(5),
		POS_W'(5), POS_W'(7), POS_W'(8), POS_W'(8), POS_W'(9)
	};

	// True when keyword k has the given letter at position pos.
	function automatic logic kw_letter_match(logic [KW_IDX_W-1:0] k, pos_t pos, char_t c);
		pos_t idx;
		idx = KW_LEN[k] - POS_W'(1) - pos;
		if (pos < KW_LEN[k]) begin
			return KW_TEXT[k][idx[CH_IDX_W-1:0]] == c;
		end
		return 1'b0;
	endfunction

	// True when the letters read so far form a whole keyword still in the mask.
	function automatic logic word_complete(word_mask_t mask, pos_t pos);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < NUM_WORDS; k++) begin
			if (mask[k] && KW_LEN[k] == pos) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

// File: sv/dmv_in_if.sv
// Input channel of the validator: one byte of the value and a last-byte flag.
// Depends on dmv_pkg for the byte type.
interface dmv_in_if;
	import dmv_pkg::*;

	logic  valid;
	logic  ready;
	char_t char_byte;
	logic  is_last;

	modport source (output valid, output char_byte, output is_last, input ready);
	modport sink   (input valid, input char_byte, input is_last, output ready);
endinterface

// File: sv/dmv_out_if.sv
// Result channel of the validator: one verdict per value.
// Standalone; no package types needed.
interface dmv_out_if;
	logic valid;
	logic ready;
	logic invalid;

	modport source (output valid, output invalid, input ready);
	modport sink   (input valid, input invalid, output ready);
endinterface

// File: sv/delivery_method_validator_core.sv
// Delivery method syntax validator: byte-serial check of a keyword list.
// Depends on dmv_pkg, dmv_in_if and dmv_out_if.
//
//   channel       role    payload              transfer
//   char_chan     sink    char_byte, is_last   one byte of the value
//   verdict_chan  source  invalid              one verdict, after the last byte
//
// One byte per cycle sustained while no verdict is stalled; the last byte of a value passes
// through the input register, then its verdict through the result register.
// Reset clears the word tracking state and empties both registers.
// A stalled verdict holds only a last byte in the input register; other bytes
// keep flowing into the word tracker while the verdict waits.
module delivery_method_validator_core (
	input  logic       clk,
	input  logic       arst_n,
	dmv_in_if.sink     char_chan,
	dmv_out_if.source  verdict_chan
);
	import dmv_pkg::*;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_WORD  = 2'd1,
		PH_SEP   = 2'd2
	} phase_t;

	// Input register.
	logic  valid_s1;
	char_t char_s1;
	logic  last_s1;

	// Result register.
	logic valid_s2;
	logic invalid_s2;

	// Word tracking state.
	word_mask_t mask_q, mask_n;
	pos_t       pos_q, pos_n;
	phase_t     phase_q, phase_n;
	logic       dollar_q, dollar_n;
	logic       fault_q, fault_n;

	logic       adv_s1;
	logic       out_free;
	logic       verdict;
	word_mask_t base_mask, keep;
	pos_t       base_pos;
	logic       too_long;
	logic       got_space, got_dollar;

	// The input register drains unless it holds a last byte and the result slot is full and stalled.
	assign out_free = !valid_s2 || verdict_chan.ready;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign char_chan.ready = !valid_s1 || adv_s1;

	assign verdict_chan.valid   = valid_s2;
	assign verdict_chan.invalid = invalid_s2;

	assign got_space  = char_s1 == CH_SPACE;
	assign got_dollar = char_s1 == CH_DOLLAR;

	// Letter narrowing: continue the current word, or start a fresh one.
	assign base_mask = (phase_q == PH_WORD) ? mask_q : ALL_WORDS;
	assign base_pos  = (phase_q == PH_WORD) ? pos_q : '0;
	assign too_long  = base_pos >= POS_W'(MAX_WORD_LEN);

	always_comb begin
		for (int k = 0; k < NUM_WORDS; k++) begin
			keep[k] = base_mask[k] && kw_letter_match(KW_IDX_W'(k), base_pos, char_s1);
		end
	end

	// Next state for the byte in the input register.
	always_comb begin
		mask_n   = mask_q;
		pos_n    = pos_q;
		phase_n  = phase_q;
		dollar_n = dollar_q;
		fault_n  = fault_q;
		if (!fault_q) begin
			unique case (phase_q)
				PH_START: begin
					if (got_space || got_dollar) begin
						fault_n = 1'b1;
					end else begin
						phase_n  = PH_WORD;
						dollar_n = 1'b0;
						mask_n   = keep;
						pos_n    = base_pos + POS_W'(1);
						fault_n  = keep == '0;
					end
				end
				PH_WORD: begin
					if (got_space || got_dollar) begin
						fault_n  = !word_complete(mask_q, pos_q);
						phase_n  = PH_SEP;
						dollar_n = got_dollar;
					end else if (too_long) begin
						fault_n = 1'b1;
					end else begin
						mask_n  = keep;
						pos_n   = base_pos + POS_W'(1);
						fault_n = keep == '0;
					end
				end
				PH_SEP: begin
					if (got_space) begin
						fault_n = 1'b0;
					end else if (got_dollar) begin
						fault_n  = dollar_q;
						dollar_n = 1'b1;
					end else if (!dollar_q) begin
						fault_n = 1'b1;
					end else begin
						phase_n  = PH_WORD;
						dollar_n = 1'b0;
						mask_n   = keep;
						pos_n    = base_pos + POS_W'(1);
						fault_n  = keep == '0;
					end
				end
				default: begin
					fault_n = 1'b1;
				end
			endcase
		end
	end

	assign verdict = !(!fault_n && phase_n == PH_WORD && word_complete(mask_n, pos_n));

	// Control state, tracking state and the valid bits of both registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			mask_q   <= ALL_WORDS;
			pos_q    <= '0;
			phase_q  <= PH_START;
			dollar_q <= 1'b0;
			fault_q  <= 1'b0;
		end else begin
			if (char_chan.ready) begin
				valid_s1 <= char_chan.valid;
			end
			if (adv_s1 && last_s1) begin
				valid_s2 <= 1'b1;
			end else if (verdict_chan.ready) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s1) begin
				if (last_s1) begin
					mask_q   <= ALL_WORDS;
					pos_q    <= '0;
					phase_q  <= PH_START;
					dollar_q <= 1'b0;
					fault_q  <= 1'b0;
				end else begin
					mask_q   <= mask_n;
					pos_q    <= pos_n;
					phase_q  <= phase_n;
					dollar_q <= dollar_n;
					fault_q  <= fault_n;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (char_chan.ready && char_chan.valid) begin
			char_s1 <= char_chan.char_byte;
			last_s1 <= char_chan.is_last;
		end
		if (adv_s1 && last_s1) begin
			invalid_s2 <= verdict;
		end
	end

endmodule

// File: sv/dmv_checker.sv
// Port-level checks for the delivery method validator, bound to its top level.
// Depends on dmv_pkg and delivery_method_validator_core.
module dmv_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         in_valid,
	input logic         in_ready,
	input logic         in_last,
	input dmv_pkg::char_t in_char,
	input logic         out_valid,
	input logic         out_ready,
	input logic         out_invalid
);
	import dmv_pkg::*;

	logic [1:0] pending_q;
	logic       in_xfer, out_xfer;

	assign in_xfer     = in_valid && in_ready && in_last;
	assign out_xfer    = out_valid && out_ready;

	// Last bytes transferred in whose verdict has not yet been transferred out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pending_q <= pending_q + 2'd1;
		end else if (!in_xfer && out_xfer) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	// A stalled verdict holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_invalid))
		else $error("verdict changed while stalled");

	// Input is refused only while a verdict is stalled.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused with free result slot");

	// No more than two values are in flight.
	a_pending_max: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("too many values in flight");

	// Every verdict belongs to a value whose last byte came in.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("verdict without a finished value");

	// An offered byte is always a known value.
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> !$isunknown(in_char))
		else $error("unknown byte offered");

endmodule

bind delivery_method_validator_core dmv_checker u_dmv_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (char_chan.valid),
	.in_ready    (char_chan.ready),
	.in_last     (char_chan.is_last),
	.in_char     (char_chan.char_byte),
	.out_valid   (verdict_chan.valid),
	.out_ready   (verdict_chan.ready),
	.out_invalid (verdict_chan.invalid)
);

// File: test/tb_delivery_method_validator_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for delivery_method_validator_core: streams value strings a byte at a
// time and checks every verdict against a local model of the keyword-list syntax.
// Depends on dmv_pkg, dmv_in_if, dmv_out_if and the core itself.
module tb_delivery_method_validator_core;
	import dmv_pkg::*;

	localparam int RANDOM_BYTES = 480;
	localparam int MAX_WAIT     = 12;
	localparam int MAX_SHOWN    = 10;
	localparam char_t CASE_BIT  = 8'h20;

	typedef enum logic [1:0] {PH_START, PH_WORD, PH_SEP} parse_phase_t;

	typedef enum int {
		MUT_CASE, MUT_BYTE, MUT_DROP, MUT_DOLLAR, MUT_NO_DOLLAR, MUT_TRAIL, MUT_LEAD, MUT_EXTEND
	} mutation_t;

	// One byte of a value as the sender will present it.
	typedef struct {
		char_t ch;
		logic  last;
		bit    drain;
	} byte_xfer_t;

	logic clk = 1'b0;
	logic arst_n;

	dmv_in_if  char_chan ();
	dmv_out_if verdict_chan ();

	delivery_method_validator_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_chan    (char_chan),
		.verdict_chan (verdict_chan)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	string keywords [NUM_WORDS] = '{
		"any", "mhs", "ia5", "telex", "g3fax",
		"g4fax", "teletex", "physical", "videotex", "telephone"
	};

	// Parser state mirrored by the testbench.
	word_mask_t   cand_mask;
	pos_t         letters_read;
	parse_phase_t parse_phase;
	logic         dollar_in_sep;
	logic         syntax_fault;

	logic       expected_verdicts [$];
	byte_xfer_t pending [$];
	char_t      value_buf [$];

	int mismatches, bytes_sent, values_queued, random_bytes;
	int valid_verdicts, invalid_verdicts;
	int gap_left, stall_left;
	bit send_quiet, take_quiet;

	function automatic int draw_wait(bit quiet);
		return quiet ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	task automatic clear_parser();
		cand_mask     = ALL_WORDS;
		letters_read  = '0;
		parse_phase   = PH_START;
		dollar_in_sep = 1'b0;
		syntax_fault  = 1'b0;
	endtask

	// True when the letters read so far spell a keyword that is still a candidate.
	function automatic logic keyword_complete();
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < NUM_WORDS; k++) begin
			if (cand_mask[k] && keywords[k].len() == int'(letters_read)) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	// Keep only keywords that have this letter at the current position.
	task automatic narrow_by_letter(input char_t c);
		word_mask_t keep;
		keep = '0;
		if (int'(letters_read) >= MAX_WORD_LEN) begin
			syntax_fault = 1'b1;
			return;
		end
		for (int k = 0; k < NUM_WORDS; k++) begin
			if (cand_mask[k] && int'(letters_read) < keywords[k].len() &&
			    char_t'(keywords[k][letters_read]) == c) begin
				keep[k] = 1'b1;
			end
		end
		cand_mask    = keep;
		letters_read = letters_read + 1'b1;
		if (keep == '0) begin
			syntax_fault = 1'b1;
		end
	endtask

	task automatic start_keyword(input char_t c);
		cand_mask     = ALL_WORDS;
		letters_read  = '0;
		dollar_in_sep = 1'b0;
		parse_phase   = PH_WORD;
		narrow_by_letter(c);
	endtask

	// Advance the parser by one transferred byte; a last byte queues the expected verdict.
	task automatic parse_byte(input char_t c, input logic last);
		logic got_space, got_dollar;
		got_space  = (c == CH_SPACE);
		got_dollar = (c == CH_DOLLAR);
		if (!syntax_fault) begin
			case (parse_phase)
				PH_START: begin
					if (got_space || got_dollar) syntax_fault = 1'b1;
					else start_keyword(c);
				end
				PH_WORD: begin
					if (got_space || got_dollar) begin
						if (!keyword_complete()) syntax_fault = 1'b1;
						parse_phase   = PH_SEP;
						dollar_in_sep = got_dollar;
					end else begin
						narrow_by_letter(c);
					end
				end
				PH_SEP: begin
					if (got_dollar) begin
						if (dollar_in_sep) syntax_fault = 1'b1;
						dollar_in_sep = 1'b1;
					end else if (!got_space) begin
						if (!dollar_in_sep) syntax_fault = 1'b1;
						else start_keyword(c);
					end
				end
				default: begin
					syntax_fault = 1'b1;
				end
			endcase
		end
		if (last) begin
			expected_verdicts.push_back(!(!syntax_fault && parse_phase == PH_WORD &&
			                              keyword_complete()));
			clear_parser();
		end
	endtask

	task automatic report_mismatch(input string what, input logic want, input logic got);
		mismatches++;
		if (mismatches <= MAX_SHOWN) begin
			$display("[%0t] %s: expected invalid=%b, got invalid=%b", $realtime, what, want, got);
		end
	endtask

	task automatic add_byte(input char_t c);
		value_buf.push_back(c);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			value_buf.push_back(char_t'(s[i]));
		end
	endtask

	// Move the assembled value into the sender queue, flagging its last byte.
	task automatic commit_value(input bit drain);
		for (int i = 0; i < value_buf.size(); i++) begin
			pending.push_back('{ch: value_buf[i], last: (i == value_buf.size() - 1),
			                    drain: (drain && i == 0)});
		end
		value_buf.delete();
		values_queued++;
	endtask

	// Mostly well-formed keyword lists, some damaged by one mutation, a few raw noise.
	task automatic build_random_value(input bit drain);
		int        words, idx;
		mutation_t mut;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6)) add_byte(char_t'($urandom_range(0, 255)));
		end else begin
			words = $urandom_range(1, 4);
			for (int w = 0; w < words; w++) begin
				if (w != 0) begin
					repeat ($urandom_range(0, 2)) add_byte(CH_SPACE);
					add_byte(CH_DOLLAR);
					repeat ($urandom_range(0, 2)) add_byte(CH_SPACE);
				end
				add_text(keywords[$urandom_range(0, NUM_WORDS - 1)]);
			end
			if ($urandom_range(0, 9) < 3) begin
				mut = mutation_t'($urandom_range(MUT_CASE, MUT_EXTEND));
				idx = $urandom_range(0, value_buf.size() - 1);
				case (mut)
					MUT_CASE:   value_buf[idx] = value_buf[idx] ^ CASE_BIT;
					MUT_BYTE:   value_buf[idx] = char_t'($urandom_range(0, 255));
					MUT_DROP:   if (value_buf.size() > 1) value_buf.delete(idx);
					MUT_DOLLAR: value_buf.insert(idx, CH_DOLLAR);
					MUT_NO_DOLLAR: begin
						foreach (value_buf[i]) begin
							if (value_buf[i] == CH_DOLLAR) value_buf[i] = CH_SPACE;
						end
						value_buf.insert(idx, CH_SPACE);
					end
					MUT_TRAIL:  add_byte($urandom_range(0, 1) ? CH_SPACE : CH_DOLLAR);
					MUT_LEAD:   value_buf.push_front($urandom_range(0, 1) ? CH_SPACE : CH_DOLLAR);
					default:    add_byte(char_t'($urandom_range(8'h61, 8'h7a)));
				endcase
			end
		end
		random_bytes += value_buf.size();
		commit_value(drain);
	endtask

	// Sender: presents queued bytes with random gaps and obeys the ready flag.
	always @(posedge clk or negedge arst_n) begin
		byte_xfer_t next_xfer;
		if (!arst_n) begin
			char_chan.valid     <= 1'b0;
			char_chan.char_byte <= '0;
			char_chan.is_last   <= 1'b0;
			gap_left   = 0;
			send_quiet = 1'b0;
			clear_parser();
		end else begin
			if (char_chan.valid && char_chan.ready) begin
				parse_byte(char_chan.char_byte, char_chan.is_last);
				bytes_sent++;
			end
			if (!char_chan.valid || char_chan.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					char_chan.valid <= 1'b0;
				end else if (pending.size() != 0 &&
				             !(pending[0].drain && expected_verdicts.size() != 0)) begin
					next_xfer = pending.pop_front();
					char_chan.valid     <= 1'b1;
					char_chan.char_byte <= next_xfer.ch;
					char_chan.is_last   <= next_xfer.last;
					gap_left = draw_wait(send_quiet);
					if ($urandom_range(0, 31) == 0) send_quiet = !send_quiet;
				end else begin
					char_chan.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each verdict transfer and stalls at random afterwards.
	always @(posedge clk or negedge arst_n) begin
		logic want;
		if (!arst_n) begin
			verdict_chan.ready <= 1'b0;
			stall_left = 0;
			take_quiet = 1'b0;
		end else begin
			if (verdict_chan.valid && verdict_chan.ready) begin
				if (expected_verdicts.size() == 0) begin
					report_mismatch("unexpected verdict", 1'bx, verdict_chan.invalid);
				end else begin
					want = expected_verdicts.pop_front();
					if (verdict_chan.invalid !== want) begin
						report_mismatch("verdict mismatch", want, verdict_chan.invalid);
					end else if (want) begin
						invalid_verdicts++;
					end else begin
						valid_verdicts++;
					end
				end
				stall_left = draw_wait(take_quiet);
				if ($urandom_range(0, 15) == 0) take_quiet = !take_quiet;
			end else if (stall_left > 0) begin
				stall_left--;
			end
			verdict_chan.ready <= (stall_left == 0);
		end
	end

	// Stimulus, reset and end-of-run check.
	initial begin
		int drain_cycles;
		arst_n = 1'b0;

		// Directed values: longest keyword, spaced separator, and the error cases.
		add_text("telephone");   commit_value(1'b0);
		add_text("ia5 $ telex"); commit_value(1'b0);
		add_text(" mhs");        commit_value(1'b0);
		add_text("$");           commit_value(1'b0);
		add_text("g3fax$");      commit_value(1'b0);
		add_text("any$$mhs");    commit_value(1'b0);
		add_text("any mhs");     commit_value(1'b0);
		add_text("Any");         commit_value(1'b0);
		add_text("telephones");  commit_value(1'b0);
		add_text("tele");        commit_value(1'b0);
		add_byte(8'hFF);         commit_value(1'b0);

		// Random values; the first and an occasional later one wait for a quiet block.
		build_random_value(1'b1);
		while (random_bytes < RANDOM_BYTES) begin
			build_random_value($urandom_range(0, 39) == 0);
		end

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending.size() != 0 || char_chan.valid) @(negedge clk);
		drain_cycles = 0;
		while (expected_verdicts.size() != 0 && drain_cycles < 2000) begin
			@(negedge clk);
			drain_cycles++;
		end
		repeat (8) @(negedge clk);
		if (expected_verdicts.size() != 0) begin
			$display("%0d expected verdicts never arrived", expected_verdicts.size());
			mismatches += expected_verdicts.size();
		end

		$display("Sent %0d bytes in %0d values under random gaps and stalls.",
		         bytes_sent, values_queued);
		$display("Matched %0d valid and %0d invalid verdicts; %0d mismatches.",
		         valid_verdicts, invalid_verdicts, mismatches);
		if (mismatches == 0) begin
			$display("** delivery_method_validator_core: PASSED **");
		end else begin
			$display("** delivery_method_validator_core: FAILED **");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("Timeout with %0d bytes and %0d verdicts outstanding.",
		         pending.size(), expected_verdicts.size());
		$display("** delivery_method_validator_core: FAILED **");
		$finish;
	end

endmodule

// File: filelist.f
sv/dmv_pkg.sv
sv/dmv_in_if.sv
sv/dmv_out_if.sv
sv/delivery_method_validator_core.sv
sv/dmv_checker.sv
test/tb_delivery_method_validator_core.sv
